@@ hw/rtl/taz_pkg.sv @@
// shared types, constants and lookup functions for the temperature alarm zone display
package taz_pkg;

  // register indexes on the configuration port
  localparam logic [7:0] REG_LOW_WARN_UPPER  = 8'd0;
  localparam logic [7:0] REG_LOW_WARN_LOWER  = 8'd1;
  localparam logic [7:0] REG_HIGH_WARN_LOWER = 8'd2;
  localparam logic [7:0] REG_HIGH_WARN_UPPER = 8'd3;

  localparam logic [15:0] RST_LOW_WARN_UPPER  = 16'd260;
  localparam logic [15:0] RST_LOW_WARN_LOWER  = 16'd250;
  localparam logic [15:0] RST_HIGH_WARN_LOWER = 16'd300;
  localparam logic [15:0] RST_HIGH_WARN_UPPER = 16'd320;

  // largest value the three digits can show
  localparam logic [9:0] DISPLAY_MAX = 10'd999;
  localparam logic [7:0] SEG_DP      = 8'h80;

  // depth of the queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    ZONE_NORMAL      = 3'd0,
    ZONE_MILD_LOW    = 3'd1,
    ZONE_SEVERE_LOW  = 3'd2,
    ZONE_MILD_HIGH   = 3'd3,
    ZONE_SEVERE_HIGH = 3'd4
  } zone_t;

  // classified beat passed from front to back
  typedef struct packed {
    logic [15:0] tenths;
    zone_t       zone;
    logic        ovf;
    logic [9:0]  shown;
    logic [6:0]  q10;
  } taz_item_t;

  function automatic logic [3:0] zone_led(input zone_t z);
    logic [3:0] led;
    unique case (z)
      ZONE_MILD_LOW:    led = 4'h1;
      ZONE_SEVERE_LOW:  led = 4'h3;
      ZONE_MILD_HIGH:   led = 4'h4;
      ZONE_SEVERE_HIGH: led = 4'hc;
      default:          led = 4'h0;
    endcase
    return led;
  endfunction

  function automatic logic [5:0] zone_beep(input zone_t z);
    logic [5:0] b;
    unique case (z)
      ZONE_MILD_LOW, ZONE_MILD_HIGH:     b = 6'd40;
      ZONE_SEVERE_LOW, ZONE_SEVERE_HIGH: b = 6'd10;
      default:                           b = 6'd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

@@ hw/rtl/temperature_alarm_zone_display_core.sv @@
// top level of the temperature alarm zone display
//
//  channel  ports                          role
//  in       in_valid/in_ready, in_*        raw sensor reading beats
//  out      out_valid/out_ready, out_*     tenths, zone, alarms, segment codes
//  cfg      cfg_we, cfg_addr, cfg_wdata    threshold registers 0..3, write only
//
// one beat per cycle sustained while out_ready is high; a beat passes the queue and the output register
// the front converts and classifies combinationally, a two-entry queue decouples it
// from the back, which splits digits and decodes into the output register
// rst_n is synchronous: clears queue and output valid, restores default thresholds
// in_ready is low while the queue holds two beats, which only an output stall causes
module temperature_alarm_zone_display_core import taz_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_raw_reading,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_tenths,
  output logic [2:0]  out_zone,
  output logic [3:0]  out_led_mask,
  output logic [5:0]  out_beep_half_period,
  output logic [7:0]  out_seg_hundreds,
  output logic [7:0]  out_seg_tens,
  output logic [7:0]  out_seg_units,
  output logic        out_display_overflow
);

  taz_item_t front_item;
  taz_item_t q_item;
  logic      q_full;
  logic      q_not_empty;
  logic      q_pop;
  logic      push;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  taz_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .raw_reading (in_raw_reading),
    .item        (front_item)
  );

  taz_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_item)
  );

  taz_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_not_empty          (q_not_empty),
    .q_item               (q_item),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_tenths           (out_tenths),
    .out_zone             (out_zone),
    .out_led_mask         (out_led_mask),
    .out_beep_half_period (out_beep_half_period),
    .out_seg_hundreds     (out_seg_hundreds),
    .out_seg_tens         (out_seg_tens),
    .out_seg_units        (out_seg_units),
    .out_display_overflow (out_display_overflow)
  );

endmodule

@@ hw/rtl/taz_front.sv @@
// front end: threshold registers, conversion to tenths and zone classification
module taz_front import taz_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic [15:0] raw_reading,
  output taz_item_t   item
);

  logic [15:0] low_warn_upper_r;
  logic [15:0] low_warn_lower_r;
  logic [15:0] high_warn_lower_r;
  logic [15:0] high_warn_upper_r;

  logic [18:0] scaled;
  logic [15:0] tenths;
  logic        ovf;
  logic [9:0]  shown;
  logic [17:0] prod10;
  zone_t       zone;

  // threshold registers, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_warn_upper_r  <= RST_LOW_WARN_UPPER;
      low_warn_lower_r  <= RST_LOW_WARN_LOWER;
      high_warn_lower_r <= RST_HIGH_WARN_LOWER;
      high_warn_upper_r <= RST_HIGH_WARN_UPPER;
    end else if (cfg_we) begin
      priority case (cfg_addr)
        REG_LOW_WARN_UPPER:  low_warn_upper_r  <= cfg_wdata;
        REG_LOW_WARN_LOWER:  low_warn_lower_r  <= cfg_wdata;
        REG_HIGH_WARN_LOWER: high_warn_lower_r <= cfg_wdata;
        REG_HIGH_WARN_UPPER: high_warn_upper_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // tenths = (raw*5 + 4) >> 3, rounded to nearest
  assign scaled = {1'b0, raw_reading, 2'b00} + {3'b000, raw_reading} + 19'd4;
  assign tenths = scaled[18:3];

  // display saturation and first quotient by ten (x*205 >> 11 exact below 1029)
  assign ovf    = (tenths > {6'd0, DISPLAY_MAX});
  assign shown  = ovf ? DISPLAY_MAX : tenths[9:0];
  assign prod10 = {8'd0, shown} * 18'd205;

  // ordered zone tests, first match wins
  always_comb begin
    priority if (tenths > low_warn_lower_r && tenths <= low_warn_upper_r) begin
      zone = ZONE_MILD_LOW;
    end else if (tenths <= low_warn_lower_r) begin
      zone = ZONE_SEVERE_LOW;
    end else if (tenths < high_warn_upper_r && tenths >= high_warn_lower_r) begin
      zone = ZONE_MILD_HIGH;
    end else if (tenths >= high_warn_upper_r) begin
      zone = ZONE_SEVERE_HIGH;
    end else begin
      zone = ZONE_NORMAL;
    end
  end

  assign item.tenths = tenths;
  assign item.zone   = zone;
  assign item.ovf    = ovf;
  assign item.shown  = shown;
  assign item.q10    = prod10[17:11];

endmodule

@@ hw/rtl/taz_queue.sv @@
// short queue of classified beats between front and back
module taz_queue import taz_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  taz_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output taz_item_t pop_item
);

  taz_item_t         mem [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_r;
  logic [QPtrW-1:0]  rd_ptr_r;
  logic [QCntW-1:0]  cnt_r;
  logic [QCntW-1:0]  cnt_nxt;

  assign full      = (cnt_r == QCntW'(QueueDepth));
  assign not_empty = (cnt_r != '0);
  assign pop_item  = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // no overrun or underrun, count within the depth
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue written while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop) else $error("queue read while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCntW'(QueueDepth)) else $error("queue count out of range");

endmodule

@@ hw/rtl/taz_back.sv @@
// back end: digit split, segment and alarm decode into the output register
module taz_back import taz_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_not_empty,
  input  taz_item_t   q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_tenths,
  output logic [2:0]  out_zone,
  output logic [3:0]  out_led_mask,
  output logic [5:0]  out_beep_half_period,
  output logic [7:0]  out_seg_hundreds,
  output logic [7:0]  out_seg_tens,
  output logic [7:0]  out_seg_units,
  output logic        out_display_overflow
);

  logic        out_valid_r;
  logic [15:0] tenths_r;
  zone_t       zone_r;
  logic [3:0]  led_r;
  logic [5:0]  beep_r;
  logic [7:0]  seg_h_r;
  logic [7:0]  seg_t_r;
  logic [7:0]  seg_u_r;
  logic        ovf_r;

  logic [14:0] prod100;
  logic [3:0]  dig_h;
  logic [6:0]  h_times10;
  logic [6:0]  tens_full;
  logic [9:0]  q_times10;
  logic [9:0]  units_full;

  // take a beat when the output register is free or being emptied
  assign q_pop = q_not_empty && (!out_valid_r || out_ready);

  // digits: hundreds from q10/10, the rest by subtraction
  assign prod100    = {8'd0, q_item.q10} * 15'd205;
  assign dig_h      = prod100[14:11];
  assign h_times10  = {dig_h, 3'b000} + {2'b00, dig_h, 1'b0};
  assign tens_full  = q_item.q10 - h_times10;
  assign q_times10  = {q_item.q10, 3'b000} + {2'b00, q_item.q10, 1'b0};
  assign units_full = q_item.shown - q_times10;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      tenths_r <= q_item.tenths;
      zone_r   <= q_item.zone;
      led_r    <= zone_led(q_item.zone);
      beep_r   <= zone_beep(q_item.zone);
      seg_h_r  <= seg_code(dig_h);
      seg_t_r  <= seg_code(tens_full[3:0]) | SEG_DP;
      seg_u_r  <= seg_code(units_full[3:0]);
      ovf_r    <= q_item.ovf;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_tenths           = tenths_r;
  assign out_zone             = zone_r;
  assign out_led_mask         = led_r;
  assign out_beep_half_period = beep_r;
  assign out_seg_hundreds     = seg_h_r;
  assign out_seg_tens         = seg_t_r;
  assign out_seg_units        = seg_u_r;
  assign out_display_overflow = ovf_r;

  // saturated display reads 99.9
  a_ovf_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ovf_r) |-> (seg_h_r == seg_code(4'd9) && seg_u_r == seg_code(4'd9)))
    else $error("overflow display not saturated");
  a_normal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && zone_r == ZONE_NORMAL) |-> (led_r == 4'h0 && beep_r == 6'd0))
    else $error("alarm outputs active in normal zone");
  a_tens_dp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (seg_t_r[7] && !seg_h_r[7] && !seg_u_r[7]))
    else $error("decimal point on wrong digit");

endmodule
